### hw/rtl/bpa_pkg.sv
// Buddy page allocator: shared types and constants.
// No dependencies.
`timescale 1ns / 1ps
package bpa_pkg;
	localparam int PAGES_DEF = 1024;
	localparam int ORDER_LIMIT_DEF = 10;
	localparam int POOL_W = 11;
	localparam int ORD_W = 4;
	localparam int PAGE_W = 10;
	localparam int STATUS_W = 2;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_ORDER   = 2'd1,
		ST_NOFREE  = 2'd2,
		ST_RANGE   = 2'd3
	} status_t;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;
endpackage

### hw/rtl/bpa_chan_if.sv
// Valid/ready channel interfaces for the allocator.
// No dependencies.
`timescale 1ns / 1ps
interface bpa_req_if;
	logic valid;
	logic ready;
	logic kind;
	logic [3:0] order;
	logic [9:0] page;
	modport source (output valid, kind, order, page, input ready);
	modport sink (input valid, kind, order, page, output ready);
endinterface

interface bpa_rsp_if;
	logic valid;
	logic ready;
	logic [1:0] status;
	logic [9:0] block_page;
	modport source (output valid, status, block_page, input ready);
	modport sink (input valid, status, block_page, output ready);
endinterface

interface bpa_cfg_if;
	logic valid;
	logic ready;
	logic [10:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

### hw/rtl/buddy_page_allocator_unit.sv
// Buddy page allocator top level: sequencer, free-list memory, taken bitmap.
// Depends on bpa_pkg and the channel interfaces in bpa_chan_if.sv.
//
//  channel | dir | payload                 | accepted when
//  req     | in  | kind, order, page       | valid && ready
//  rsp     | out | status, block_page      | valid && ready
//  cfg     | in  | pool_pages (data)       | valid && ready
//
// Order and range rejects answer the cycle after acceptance. Others step
// through the orders scanned or split, the pages marked, the buddy pages
// tested at each level and the stack entries searched or moved down.
// Reset and every pool write clear the bitmap, then carve the pool into
// blocks; nothing is taken meanwhile. Requests and pool writes are taken
// only when idle with the response slot empty; a pool write wins.
`timescale 1ns / 1ps
module buddy_page_allocator_unit #(
	parameter int PAGES = bpa_pkg::PAGES_DEF,
	parameter int ORDER_LIMIT = bpa_pkg::ORDER_LIMIT_DEF
) (
	input logic clk,
	input logic arst_n,
	bpa_req_if.sink req,
	bpa_rsp_if.source rsp,
	bpa_cfg_if.sink cfg
);
	import bpa_pkg::*;

	localparam int PW = $clog2(PAGES);
	localparam int CW = PW + 1;
	localparam int NORD = ORDER_LIMIT + 1;
	localparam int OW = $clog2(NORD + 1);
	localparam int AW = $clog2(NORD) + PW;
	localparam int VW = PW + 2;

	typedef enum logic [10:0] {
		S_CLR    = 11'b00000000001,
		S_CARVE  = 11'b00000000010,
		S_IDLE   = 11'b00000000100,
		S_SCAN   = 11'b00000001000,
		S_POPRD  = 11'b00000010000,
		S_SPLIT  = 11'b00000100000,
		S_MARK   = 11'b00001000000,
		S_CHK    = 11'b00010000000,
		S_FIND   = 11'b00100000000,
		S_SHIFT  = 11'b01000000000,
		S_PUSH   = 11'b10000000000
	} state_t;

	state_t state_q;
	logic [CW-1:0] pool_q;
	logic [CW-1:0] cnt_q [NORD];
	logic [PW-1:0] stk_mem [NORD*PAGES];
	logic [PW-1:0] rd_q;
	logic taken_q [PAGES];
	logic taken_rd_q;

	logic [OW-1:0] mo_q, ord_q, k_q;
	logic [VW-1:0] cur_q, rem_q, idx_q, end_q;
	logic [CW-1:0] i_q;
	logic kind_q;
	logic rsp_v_q;
	logic [1:0] rsp_st_q;
	logic [PW-1:0] rsp_pg_q;
	logic mark_v_q;
	logic chk_v_q;

	// max order of a pool size
	function automatic logic [OW-1:0] max_ord(input logic [CW-1:0] v);
		logic [OW-1:0] r;
		r = '0;
		for (int b = 0; b < CW; b++)
			if (v[b]) r = OW'(b);
		if (r > OW'(ORDER_LIMIT)) r = OW'(ORDER_LIMIT);
		return r;
	endfunction

	function automatic logic [AW-1:0] addr(input logic [OW-1:0] k,
		input logic [CW-1:0] i);
		return AW'(k) * AW'(PAGES) + AW'(i[PW-1:0]);
	endfunction

	logic [CW-1:0] cfg_pool;
	always_comb begin
		cfg_pool = (cfg.data[POOL_W-1:0] == '0) ? CW'(1) :
			((32'(cfg.data) > PAGES) ? CW'(PAGES) : CW'(cfg.data));
	end

	// largest block order fitting remaining count, clipped to max order
	logic [OW-1:0] carve_o;
	assign carve_o = (max_ord(CW'(rem_q)) > mo_q) ? mo_q : max_ord(CW'(rem_q));

	logic [VW-1:0] bs;
	assign bs = VW'(1) << k_q;

	assign req.ready = (state_q == S_IDLE) && !rsp_v_q && !cfg.valid;
	assign cfg.ready = (state_q == S_IDLE) && !rsp_v_q;
	assign rsp.valid = rsp_v_q;
	assign rsp.status = rsp_st_q;
	assign rsp.block_page = rsp_st_q == ST_OK ? PAGE_W'(rsp_pg_q) : '0;

	logic [PW-1:0] wr_d;
	logic [AW-1:0] wr_a, rd_a;
	logic wr_en;
	logic [VW-1:0] buddy;
	assign buddy = cur_q ^ bs;

	// memory write/read port selection
	always_comb begin
		wr_en = 1'b0;
		wr_a = addr(k_q, cnt_q[k_q]);
		wr_d = PW'(cur_q);
		rd_a = addr(k_q, i_q);
		unique case (state_q)
			S_CARVE: begin
				wr_en = rem_q != '0;
				wr_a = addr(carve_o, cnt_q[carve_o]);
			end
			S_SPLIT: begin
				wr_en = mark_v_q && (k_q > ord_q) &&
					(cnt_q[k_q - OW'(1)] < CW'(PAGES));
				wr_a = addr(k_q - OW'(1), cnt_q[k_q - OW'(1)]);
				wr_d = PW'(cur_q + (VW'(1) << (k_q - OW'(1))));
			end
			S_SHIFT: begin
				// idx_q[0] set: rd_q holds entry i_q + 1
				wr_en = idx_q[0] && (i_q + CW'(1) < cnt_q[k_q]);
				wr_a = addr(k_q, i_q);
				wr_d = rd_q;
				rd_a = idx_q[0] ? addr(k_q, i_q + CW'(2)) : addr(k_q, i_q + CW'(1));
			end
			S_PUSH: wr_en = cnt_q[k_q] < CW'(PAGES);
			S_FIND: rd_a = (i_q == '0) ? addr(k_q, '0) : addr(k_q, i_q - CW'(1));
			S_POPRD: rd_a = addr(k_q, cnt_q[k_q]);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) stk_mem[wr_a] <= wr_d;
		rd_q <= stk_mem[rd_a];
	end

	// bitmap, with a registered read at idx_q
	always_ff @(posedge clk) begin
		if (state_q == S_CLR) taken_q[idx_q[PW-1:0]] <= 1'b0;
		if (state_q == S_MARK && mark_v_q) taken_q[idx_q[PW-1:0]] <= !kind_q;
		taken_rd_q <= taken_q[idx_q[PW-1:0]];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			pool_q <= CW'(PAGES > 1024 ? 1024 : PAGES);
			mo_q <= max_ord(CW'(PAGES > 1024 ? 1024 : PAGES));
			rem_q <= VW'(PAGES > 1024 ? 1024 : PAGES);
			idx_q <= '0;
			cur_q <= '0;
			for (int k = 0; k < NORD; k++) cnt_q[k] <= '0;
			rsp_v_q <= 1'b0;
			rsp_st_q <= '0;
			rsp_pg_q <= '0;
			ord_q <= '0;
			k_q <= '0;
			i_q <= '0;
			end_q <= '0;
			kind_q <= 1'b0;
			mark_v_q <= 1'b0;
			chk_v_q <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) rsp_v_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					idx_q <= idx_q + VW'(1);
					if (idx_q == VW'(PAGES - 1)) state_q <= S_CARVE;
				end
				S_CARVE: begin
					if (rem_q == '0) state_q <= S_IDLE;
					else begin
						cnt_q[carve_o] <= cnt_q[carve_o] + CW'(1);
						cur_q <= cur_q + (VW'(1) << carve_o);
						rem_q <= rem_q - (VW'(1) << carve_o);
					end
				end
				S_IDLE: begin
					if (cfg.valid && cfg.ready) begin
						pool_q <= cfg_pool;
						mo_q <= max_ord(cfg_pool);
						rem_q <= VW'(cfg_pool);
						cur_q <= '0;
						idx_q <= '0;
						for (int k = 0; k < NORD; k++) cnt_q[k] <= '0;
						state_q <= S_CLR;
					end else if (req.valid && req.ready) begin
						kind_q <= req.kind;
						ord_q <= OW'(req.order);
						k_q <= OW'(req.order);
						cur_q <= VW'(req.page);
						if (req.order > 4'(mo_q)) begin
							rsp_st_q <= ST_ORDER;
							rsp_v_q <= 1'b1;
						end else if (req.kind == KIND_ALLOC) begin
							state_q <= S_SCAN;
						end else if (VW'(req.page) + (VW'(1) << req.order) >
								VW'(pool_q) ||
								(10'(req.page) & ((10'(1) << req.order) - 10'(1)))
								!= '0) begin
							rsp_st_q <= ST_RANGE;
							rsp_v_q <= 1'b1;
						end else begin
							idx_q <= VW'(req.page);
							end_q <= VW'(req.page) + (VW'(1) << req.order);
							mark_v_q <= 1'b1;
							state_q <= S_MARK;
						end
					end
				end
				S_SCAN: begin
					mark_v_q <= 1'b0;
					if (k_q > mo_q) begin
						rsp_st_q <= ST_NOFREE;
						rsp_v_q <= 1'b1;
						state_q <= S_IDLE;
					end else if (cnt_q[k_q] != '0) begin
						cnt_q[k_q] <= cnt_q[k_q] - CW'(1);
						state_q <= S_POPRD;
					end else k_q <= k_q + OW'(1);
				end
				S_POPRD: state_q <= S_SPLIT;
				S_SPLIT: begin
					// latch the popped block first, then push upper halves
					if (!mark_v_q) begin
						cur_q <= VW'(rd_q);
						mark_v_q <= 1'b1;
					end else if (k_q > ord_q) begin
						if (cnt_q[k_q - OW'(1)] < CW'(PAGES))
							cnt_q[k_q - OW'(1)] <= cnt_q[k_q - OW'(1)] + CW'(1);
						k_q <= k_q - OW'(1);
					end else begin
						idx_q <= cur_q;
						end_q <= cur_q + (VW'(1) << ord_q);
						state_q <= S_MARK;
					end
				end
				S_MARK: begin
					idx_q <= idx_q + VW'(1);
					if (idx_q + VW'(1) == end_q) begin
						if (kind_q == KIND_ALLOC) begin
							rsp_st_q <= ST_OK;
							rsp_pg_q <= PW'(cur_q);
							rsp_v_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_CHK;
						end
					end
				end
				S_CHK: begin
					// test buddy range, then its bitmap one page a cycle
					if (k_q >= mo_q || buddy + bs > VW'(pool_q)) state_q <= S_PUSH;
					else if (end_q != buddy + bs) begin
						idx_q <= buddy;
						end_q <= buddy + bs;
						chk_v_q <= 1'b0;
					end else if (chk_v_q && taken_rd_q) state_q <= S_PUSH;
					else if (idx_q == end_q) begin
						i_q <= cnt_q[k_q];
						state_q <= S_FIND;
						idx_q <= '0;
					end else begin
						idx_q <= idx_q + VW'(1);
						chk_v_q <= 1'b1;
					end
				end
				S_FIND: begin
					// idx_q[0] marks that rd_q holds entry i_q
					if (idx_q[0] && PW'(buddy) == rd_q) begin
						idx_q <= '0;
						state_q <= S_SHIFT;
					end else if (i_q == '0) state_q <= S_PUSH;
					else begin
						i_q <= i_q - CW'(1);
						idx_q <= VW'(1);
					end
				end
				S_SHIFT: begin
					if (!idx_q[0]) idx_q <= VW'(1);
					else if (i_q + CW'(1) >= cnt_q[k_q]) begin
						cnt_q[k_q] <= cnt_q[k_q] - CW'(1);
						if (buddy < cur_q) cur_q <= buddy;
						k_q <= k_q + OW'(1);
						idx_q <= '0;
						end_q <= '0;
						state_q <= S_CHK;
					end else i_q <= i_q + CW'(1);
				end
				S_PUSH: begin
					if (cnt_q[k_q] < CW'(PAGES)) cnt_q[k_q] <= cnt_q[k_q] + CW'(1);
					rsp_st_q <= ST_OK;
					rsp_pg_q <= PW'(cur_q);
					rsp_v_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_one_hot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.status))
		else $error("response dropped");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> state_q == S_IDLE && !rsp_v_q)
		else $error("request taken while busy");
`endif
endmodule

### verif/bpa_tb_chan_if.sv
// Testbench copies of nothing: channel interfaces come from the RTL file bpa_chan_if.sv.
// This file holds the stimulus table type used by the testbench top.
// Depends on bpa_pkg.
`timescale 1ns / 1ps
package bpa_tb_pkg;
	import bpa_pkg::*;

	// one directed row: request, optional typed-in expectation
	typedef struct packed {
		logic kind;
		logic [3:0] order;
		logic [9:0] page;
		logic has_exp;
		logic [1:0] exp_status;
		logic [9:0] exp_page;
	} dir_row_t;
endpackage

### verif/buddy_page_allocator_unit_tb.sv
// Testbench for the buddy page allocator: directed table, then random
// allocate/free traffic across several pool sizes, checked by a predictor.
// Depends on bpa_pkg, bpa_tb_pkg and the channel interfaces.
`timescale 1ns / 1ps
module buddy_page_allocator_unit_tb;
	import bpa_pkg::*;
	import bpa_tb_pkg::*;

	localparam int NPG = 1024;
	localparam int NORD = 10;
	localparam longint CYCLE_LIMIT = 100000000;

	logic clk;
	logic arst_n;
	bpa_req_if req ();
	bpa_rsp_if rsp ();
	bpa_cfg_if cfg ();

	buddy_page_allocator_unit u_top (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
	);

	// predictor state
	int pool_sz;
	int free_list[NORD+1][$];
	bit taken_map[NPG];
	logic [11:0] exp_q[$];
	int n_fail;
	longint cycles;
	bit rsp_hold;
	int allocated[$];
	int alloc_ord[$];

	function automatic int log2_dn(int v);
		int r;
		r = 0;
		while (v > 1) begin
			v = v >> 1;
			r++;
		end
		return r;
	endfunction

	function automatic int top_order();
		int m;
		m = log2_dn(pool_sz);
		return (m > NORD) ? NORD : m;
	endfunction

	function automatic void push_free(int k, int p);
		if (free_list[k].size() < NPG)
			free_list[k].push_back(p);
	endfunction

	function automatic void set_pool(int v);
		int mo, rem, cur, o;
		v = v & 11'h7ff;
		if (v < 1) v = 1;
		if (v > NPG) v = NPG;
		pool_sz = v;
		mo = top_order();
		for (int k = 0; k <= NORD; k++)
			free_list[k].delete();
		for (int i = 0; i < NPG; i++)
			taken_map[i] = 0;
		allocated.delete();
		alloc_ord.delete();
		rem = v;
		cur = 0;
		while (rem > 0) begin
			o = log2_dn(rem);
			if (o > mo) o = mo;
			push_free(o, cur);
			cur += 1 << o;
			rem -= 1 << o;
		end
	endfunction

	// compute status/page for one request and update the allocator image
	function automatic logic [11:0] alloc_predict(logic kind, int order, int page);
		int mo, k, res, sz, cur, co, bs, bud;
		bit clear, found;
		logic [1:0] st;
		mo = top_order();
		st = ST_OK;
		res = 0;
		if (order > mo) begin
			st = ST_ORDER;
		end else if (kind == KIND_ALLOC) begin
			k = order;
			while (k <= mo && free_list[k].size() == 0) k++;
			if (k > mo) begin
				st = ST_NOFREE;
			end else begin
				res = free_list[k].pop_back();
				while (k > order) begin
					k--;
					push_free(k, res + (1 << k));
				end
				for (int j = 0; j < (1 << order); j++)
					if (res + j < NPG) taken_map[res + j] = 1;
				allocated.push_back(res);
				alloc_ord.push_back(order);
			end
		end else begin
			sz = 1 << order;
			if (page + sz > pool_sz || (page & (sz - 1)) != 0) begin
				st = ST_RANGE;
			end else begin
				for (int j = 0; j < sz; j++) taken_map[page + j] = 0;
				cur = page;
				co = order;
				while (co < mo) begin
					bs = 1 << co;
					bud = cur ^ bs;
					if (bud + bs > pool_sz) break;
					clear = 1;
					for (int j = 0; j < bs; j++)
						if (bud + j >= NPG || taken_map[bud + j]) clear = 0;
					if (!clear) break;
					found = 0;
					for (int i = free_list[co].size() - 1; i >= 0; i--)
						if (!found && free_list[co][i] == bud) begin
							free_list[co].delete(i);
							found = 1;
						end
					if (!found) break;
					if (bud < cur) cur = bud;
					co++;
				end
				push_free(co, cur);
				res = cur;
			end
		end
		return {st, (st == ST_OK) ? res[9:0] : 10'd0};
	endfunction

	// clock and cycle limit
	initial begin
		clk = 0;
		forever begin
			#5 clk = ~clk;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// response side: random stalls, long hold when asked
	initial begin
		int w;
		rsp.ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rsp_hold) begin
				rsp.ready <= 0;
			end else begin
				w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
				if (w > 0) begin
					rsp.ready <= 0;
					repeat (w) @(negedge clk);
				end
				rsp.ready <= 1;
				@(posedge clk);
				while (!rsp.valid) @(posedge clk);
			end
		end
	end

	// response checker
	always @(posedge clk) begin
		logic [11:0] e;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (exp_q.size() == 0) begin
				$display("%0t: unexpected response status=%0d page=%0d", $time,
					rsp.status, rsp.block_page);
				n_fail++;
			end else begin
				e = exp_q.pop_front();
				if (rsp.status !== e[11:10])
					$display("%0t: status mismatch exp=%0d got=%0d", $time, e[11:10],
						rsp.status);
				if (rsp.block_page !== e[9:0])
					$display("%0t: block_page mismatch exp=%0d got=%0d", $time, e[9:0],
						rsp.block_page);
				if (rsp.status !== e[11:10] || rsp.block_page !== e[9:0]) n_fail++;
			end
		end
	end

	task automatic send_request(logic kind, int order, int page, bit has_exp,
		logic [11:0] typed, bit gaps);
		logic [11:0] e;
		@(negedge clk);
		if (gaps && $urandom_range(0, 2) != 0)
			repeat ($urandom_range(0, 7)) @(negedge clk);
		req.valid <= 1;
		req.kind <= kind;
		req.order <= order[3:0];
		req.page <= page[9:0];
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		e = alloc_predict(kind, order, page);
		if (has_exp && e !== typed) begin
			$display("%0t: typed expectation differs exp=%0h pred=%0h", $time, typed, e);
			n_fail++;
		end
		exp_q.push_back(e);
		@(negedge clk);
		req.valid <= 0;
	endtask

	task automatic drain();
		while (exp_q.size() != 0) @(posedge clk);
		// a request in flight always answers, so only settle margin here
		repeat (50) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_pool(int v);
		drain();
		cfg.valid <= 1;
		cfg.data <= v[10:0];
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		set_pool(v);
		@(negedge clk);
		cfg.valid <= 0;
	endtask

	// random mix: mostly frees of live blocks and allocations, some noise
	task automatic random_phase(int n);
		int r, idx, o, p;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 45 || allocated.size() == 0) begin
				o = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
					: $urandom_range(0, top_order() < 4 ? top_order() : 4);
				send_request(KIND_ALLOC, o, $urandom_range(0, 1023), 0, 0, 1);
			end else if (r < 88) begin
				idx = $urandom_range(0, allocated.size() - 1);
				p = allocated[idx];
				o = alloc_ord[idx];
				allocated.delete(idx);
				alloc_ord.delete(idx);
				send_request(KIND_FREE, o, p, 0, 0, 1);
			end else begin
				send_request(1'($urandom_range(0, 1)), $urandom_range(0, 15),
					$urandom_range(0, 1023), 0, 0, 1);
			end
		end
	endtask

	dir_row_t dir_tab[$];

	function automatic dir_row_t row(logic k, int o, int p, bit he, int st, int pg);
		dir_row_t d;
		d.kind = k;
		d.order = o[3:0];
		d.page = p[9:0];
		d.has_exp = he;
		d.exp_status = st[1:0];
		d.exp_page = pg[9:0];
		return d;
	endfunction

	initial begin
		cycles = 0;
		n_fail = 0;
		rsp_hold = 0;
		arst_n = 0;
		req.valid = 0;
		req.kind = 0;
		req.order = 0;
		req.page = 0;
		cfg.valid = 0;
		cfg.data = 0;
		set_pool(1024);
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed table on the reset pool of 1024 pages
		dir_tab.push_back(row(KIND_ALLOC, 11, 0, 1, ST_ORDER, 0));
		dir_tab.push_back(row(KIND_ALLOC, 15, 1023, 1, ST_ORDER, 0));
		dir_tab.push_back(row(KIND_ALLOC, 10, 0, 1, ST_OK, 0));
		dir_tab.push_back(row(KIND_ALLOC, 0, 0, 1, ST_NOFREE, 0));
		dir_tab.push_back(row(KIND_FREE, 10, 0, 1, ST_OK, 0));
		dir_tab.push_back(row(KIND_ALLOC, 0, 0, 1, ST_OK, 0));
		dir_tab.push_back(row(KIND_ALLOC, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(KIND_ALLOC, 3, 0, 0, 0, 0));
		dir_tab.push_back(row(KIND_FREE, 1, 1, 1, ST_RANGE, 0));
		dir_tab.push_back(row(KIND_FREE, 0, 1023, 0, 0, 0));
		dir_tab.push_back(row(KIND_FREE, 10, 512, 1, ST_RANGE, 0));
		dir_tab.push_back(row(KIND_FREE, 0, 1, 0, 0, 0));
		dir_tab.push_back(row(KIND_FREE, 0, 0, 0, 0, 0));
		// double free of the same page
		dir_tab.push_back(row(KIND_FREE, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(KIND_ALLOC, 9, 0, 0, 0, 0));
		dir_tab.push_back(row(KIND_FREE, 3, 8, 0, 0, 0));
		dir_tab.push_back(row(KIND_FREE, 15, 0, 1, ST_ORDER, 0));
		foreach (dir_tab[i])
			send_request(dir_tab[i].kind, dir_tab[i].order, dir_tab[i].page,
				dir_tab[i].has_exp, {dir_tab[i].exp_status, dir_tab[i].exp_page}, 1);

		// pool extremes: zero acts as one, oversize saturates
		write_pool(0);
		send_request(KIND_ALLOC, 1, 0, 1, {ST_ORDER, 10'd0}, 0);
		send_request(KIND_ALLOC, 0, 0, 1, {ST_OK, 10'd0}, 0);
		send_request(KIND_ALLOC, 0, 0, 1, {ST_NOFREE, 10'd0}, 0);
		send_request(KIND_FREE, 0, 1, 1, {ST_RANGE, 10'd0}, 0);
		send_request(KIND_FREE, 0, 0, 1, {ST_OK, 10'd0}, 0);
		write_pool(2047);
		random_phase(150);

		// sender pause until all answered, then long receiver hold
		drain();
		fork
			begin
				rsp_hold = 1;
				repeat (3000) @(posedge clk);
				rsp_hold = 0;
			end
			random_phase(30);
		join

		write_pool(1000);
		random_phase(250);
		write_pool(37);
		random_phase(250);
		write_pool(1);
		random_phase(40);
		write_pool(1024);
		random_phase(300);

		drain();
		if (n_fail == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
